// ===== rtl/core/brp_pkg.sv =====
// brp_pkg: constants, opcodes and sequencer states for the byte rate pacer
// no dependencies; used by byte_rate_pacer

package brp_pkg;

   // port geometry
   localparam int TIME_BITS_DEF = 64;
   localparam int NOW_W         = 64;
   localparam int OPCODE_W      = 2;
   localparam int WAIT_W        = 17;
   localparam int RSP_FIELDS_W  = 2 * WAIT_W + 2;
   localparam int RSP_TDATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W     = RSP_TDATA_W - RSP_FIELDS_W;
   localparam int SPEED_W       = 17;
   localparam int CSR_IDX_W     = 2;

   // interval constants in microseconds per byte
   localparam logic [WAIT_W-1:0] WAIT_MAX        = 17'd131071;
   localparam logic [WAIT_W-1:0] PRESET_INTERVAL = 17'd2778;
   localparam logic [WAIT_W-1:0] V23_RX_INTERVAL = 17'd66667;
   localparam logic [WAIT_W-1:0] V23_TX_INTERVAL = 17'd106667;

   // line speed limits in bit/s
   localparam logic [SPEED_W-1:0] TX_CLAMP    = 17'd56000;
   localparam logic [SPEED_W-1:0] RX_CLAMP    = 17'd33600;
   localparam logic [SPEED_W-1:0] TX_FLOOR    = 17'd1200;
   localparam logic [SPEED_W-1:0] RX_FLOOR    = 17'd75;
   localparam logic [SPEED_W-1:0] SPEED_RESET = 17'd28800;

   // effective speed = speed * 89 / 100, the /100 as a reciprocal multiply
   localparam int PROD_W      = 23;
   localparam int EFF_NUM     = 89;
   localparam int RECIP_W     = 24;
   localparam int RECIP_SHIFT = 30;
   localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
   localparam int SCALE_W     = PROD_W + RECIP_W;
   localparam int EFF_W       = 16;

   // restoring divide of the byte time constant by the effective speed
   localparam int DIVIDEND_W = 23;
   localparam logic [DIVIDEND_W-1:0] USEC_PER_BYTE = 23'd8000000;
   localparam int DIV_STEPS = DIVIDEND_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_SOURCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TX_SPEED     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_SPEED     = 2'd2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_QUERY = 2'd0,
      OP_RECV  = 2'd1,
      OP_SENT  = 2'd2,
      OP_PACED = 2'd3
   } opcode_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MUL   = 5'b00010,
      ST_SCALE = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_DONE  = 5'b10000
   } seq_state_type;

endpackage

// ===== rtl/core/byte_rate_pacer.sv =====
// byte_rate_pacer: per-direction byte pacing with interval recompute after csr writes
// depends on brp_pkg
//
//  channel | dir | handshake           | payload
//  req     | in  | req_tvalid/tready   | tdata: now_usec; tuser: opcode
//  rsp     | out | rsp_tvalid/tready   | tdata: read_wait, write_wait, read_ready, write_ready
//  csr     | in  | csr_we              | csr_index, csr_wdata
//
// one transaction per cycle unless stalled; result registered, valid the cycle after acceptance
// a csr write to a known index starts an interval recompute (multiply, reciprocal
// scale, 23-step restoring divide, load); req_tready stays low through it
// rsp stalls hold the result register and backpressure req the same cycle
// reset is synchronous; intervals come up at the 28.8K preset, no recompute needed

module byte_rate_pacer #(
   parameter int TIME_BITS = brp_pkg::TIME_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [brp_pkg::NOW_W-1:0]       req_tdata,   // [63:0] now_usec
   input  logic [brp_pkg::OPCODE_W-1:0]    req_tuser,   // [1:0] opcode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [16:0] read_wait_usec, [33:17] write_wait_usec, [34] read_ready, [35] write_ready
   output logic [brp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [brp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [brp_pkg::SPEED_W-1:0]     csr_wdata
);

   localparam int WAIT_W = brp_pkg::WAIT_W;
   localparam int EFF_W  = brp_pkg::EFF_W;
   localparam int DIV_W  = brp_pkg::DIVIDEND_W;
   localparam int SCALE_W_L = brp_pkg::SCALE_W;

   // configuration registers
   logic                          src_ff, src_in;
   logic [brp_pkg::SPEED_W-1:0]   tx_speed_ff, tx_speed_in;
   logic [brp_pkg::SPEED_W-1:0]   rx_speed_ff, rx_speed_in;
   logic                          cfg_hit;

   // pacing state
   logic [TIME_BITS-1:0]          next_recv_ff, next_recv_in;
   logic [TIME_BITS-1:0]          next_send_ff, next_send_in;
   logic [WAIT_W-1:0]             recv_interval_ff, recv_interval_in;
   logic [WAIT_W-1:0]             send_interval_ff, send_interval_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [brp_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // recompute sequencer
   brp_pkg::seq_state_type        state_ff, state_in;
   logic [brp_pkg::PROD_W-1:0]    rx_prod_ff, rx_prod_in, tx_prod_ff, tx_prod_in;
   logic [EFF_W-1:0]              rx_eff_ff, rx_eff_in, tx_eff_ff, tx_eff_in;
   logic [EFF_W-1:0]              rx_rem_ff, rx_rem_in, tx_rem_ff, tx_rem_in;
   logic [DIV_W-1:0]              rx_quot_ff, rx_quot_in, tx_quot_ff, tx_quot_in;
   logic [DIV_W-1:0]              dvd_ff, dvd_in;
   logic [brp_pkg::CNT_W-1:0]     cnt_ff, cnt_in;

   // datapath signals
   logic                          req_fire;
   logic [TIME_BITS-1:0]          now_t;
   logic                          rx_late, tx_late;
   logic [TIME_BITS-1:0]          rx_diff, tx_diff;
   logic [WAIT_W-1:0]             rx_wait, tx_wait;
   logic [TIME_BITS-1:0]          paced_base;
   logic [SCALE_W_L-1:0]          rx_scaled, tx_scaled;
   logic [EFF_W:0]                rx_trial, tx_trial;
   logic                          rx_qbit, tx_qbit;
   logic [brp_pkg::SPEED_W-1:0]   rx_clamped, tx_clamped;
   brp_pkg::opcode_type           opcode;

   assign cfg_hit = csr_we && (csr_index == brp_pkg::CSR_SPEED_SOURCE ||
                               csr_index == brp_pkg::CSR_TX_SPEED ||
                               csr_index == brp_pkg::CSR_RX_SPEED);

   assign req_tready = (state_ff == brp_pkg::ST_IDLE) && !cfg_hit &&
                       (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign now_t  = req_tdata[TIME_BITS-1:0];
   assign opcode = brp_pkg::opcode_type'(req_tuser);

   // waits against the state before this transaction's update
   always_comb begin
      rx_late = now_t < next_recv_ff;
      tx_late = now_t < next_send_ff;
      rx_diff = next_recv_ff - now_t;
      tx_diff = next_send_ff - now_t;
      if (!rx_late) begin
         rx_wait = '0;
      end else if (|rx_diff[TIME_BITS-1:WAIT_W]) begin
         rx_wait = brp_pkg::WAIT_MAX;
      end else begin
         rx_wait = rx_diff[WAIT_W-1:0];
      end
      if (!tx_late) begin
         tx_wait = '0;
      end else if (|tx_diff[TIME_BITS-1:WAIT_W]) begin
         tx_wait = brp_pkg::WAIT_MAX;
      end else begin
         tx_wait = tx_diff[WAIT_W-1:0];
      end
      paced_base = tx_late ? next_send_ff : now_t;
   end

   always_comb begin
      next_recv_in = next_recv_ff;
      next_send_in = next_send_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{brp_pkg::RSP_PAD_W{1'b0}}, !tx_late, !rx_late, tx_wait, rx_wait};
         unique case (opcode)
            brp_pkg::OP_QUERY: begin
            end
            brp_pkg::OP_RECV: begin
               next_recv_in = now_t + TIME_BITS'(recv_interval_ff);
            end
            brp_pkg::OP_SENT: begin
               next_send_in = now_t + TIME_BITS'(send_interval_ff);
            end
            brp_pkg::OP_PACED: begin
               next_send_in = paced_base + TIME_BITS'(send_interval_ff);
            end
            default: begin
            end
         endcase
      end
   end

   // configuration writes
   always_comb begin
      src_in      = src_ff;
      tx_speed_in = tx_speed_ff;
      rx_speed_in = rx_speed_ff;
      if (csr_we) begin
         unique case (csr_index)
            brp_pkg::CSR_SPEED_SOURCE: src_in      = csr_wdata[0];
            brp_pkg::CSR_TX_SPEED:     tx_speed_in = csr_wdata;
            brp_pkg::CSR_RX_SPEED:     rx_speed_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // interval recompute: clamp and *89, reciprocal /100, then bit-serial divide
   always_comb begin
      rx_clamped = (rx_speed_ff > brp_pkg::RX_CLAMP) ? brp_pkg::RX_CLAMP : rx_speed_ff;
      tx_clamped = (tx_speed_ff > brp_pkg::TX_CLAMP) ? brp_pkg::TX_CLAMP : tx_speed_ff;
      rx_scaled  = SCALE_W_L'(rx_prod_ff) * SCALE_W_L'(brp_pkg::RECIP_100);
      tx_scaled  = SCALE_W_L'(tx_prod_ff) * SCALE_W_L'(brp_pkg::RECIP_100);
      rx_trial   = {rx_rem_ff, dvd_ff[DIV_W-1]};
      tx_trial   = {tx_rem_ff, dvd_ff[DIV_W-1]};
      rx_qbit    = rx_trial >= {1'b0, rx_eff_ff};
      tx_qbit    = tx_trial >= {1'b0, tx_eff_ff};

      state_in         = state_ff;
      rx_prod_in       = rx_prod_ff;
      tx_prod_in       = tx_prod_ff;
      rx_eff_in        = rx_eff_ff;
      tx_eff_in        = tx_eff_ff;
      rx_rem_in        = rx_rem_ff;
      tx_rem_in        = tx_rem_ff;
      rx_quot_in       = rx_quot_ff;
      tx_quot_in       = tx_quot_ff;
      dvd_in           = dvd_ff;
      cnt_in           = cnt_ff;
      recv_interval_in = recv_interval_ff;
      send_interval_in = send_interval_ff;

      unique case (state_ff)
         brp_pkg::ST_IDLE: begin
         end
         brp_pkg::ST_MUL: begin
            rx_prod_in = brp_pkg::PROD_W'(rx_clamped) * brp_pkg::PROD_W'(brp_pkg::EFF_NUM);
            tx_prod_in = brp_pkg::PROD_W'(tx_clamped) * brp_pkg::PROD_W'(brp_pkg::EFF_NUM);
            state_in   = brp_pkg::ST_SCALE;
         end
         brp_pkg::ST_SCALE: begin
            rx_eff_in  = rx_scaled[brp_pkg::RECIP_SHIFT +: EFF_W];
            tx_eff_in  = tx_scaled[brp_pkg::RECIP_SHIFT +: EFF_W];
            rx_rem_in  = '0;
            tx_rem_in  = '0;
            rx_quot_in = '0;
            tx_quot_in = '0;
            dvd_in     = brp_pkg::USEC_PER_BYTE;
            cnt_in     = '0;
            state_in   = brp_pkg::ST_DIV;
         end
         brp_pkg::ST_DIV: begin
            rx_rem_in  = rx_qbit ? EFF_W'(rx_trial - {1'b0, rx_eff_ff}) : rx_trial[EFF_W-1:0];
            tx_rem_in  = tx_qbit ? EFF_W'(tx_trial - {1'b0, tx_eff_ff}) : tx_trial[EFF_W-1:0];
            rx_quot_in = {rx_quot_ff[DIV_W-2:0], rx_qbit};
            tx_quot_in = {tx_quot_ff[DIV_W-2:0], tx_qbit};
            dvd_in     = {dvd_ff[DIV_W-2:0], 1'b0};
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == brp_pkg::CNT_W'(brp_pkg::DIV_STEPS - 1)) begin
               state_in = brp_pkg::ST_DONE;
            end
         end
         brp_pkg::ST_DONE: begin
            priority if (!src_ff) begin
               recv_interval_in = brp_pkg::PRESET_INTERVAL;
               send_interval_in = brp_pkg::PRESET_INTERVAL;
            end else if (tx_speed_ff <= brp_pkg::TX_FLOOR ||
                         rx_speed_ff <= brp_pkg::RX_FLOOR) begin
               recv_interval_in = brp_pkg::V23_RX_INTERVAL;
               send_interval_in = brp_pkg::V23_TX_INTERVAL;
            end else begin
               recv_interval_in = (rx_eff_ff == '0) ? brp_pkg::WAIT_MAX
                                                    : rx_quot_ff[WAIT_W-1:0];
               send_interval_in = (tx_eff_ff == '0) ? brp_pkg::WAIT_MAX
                                                    : tx_quot_ff[WAIT_W-1:0];
            end
            state_in = brp_pkg::ST_IDLE;
         end
         default: begin
            state_in = brp_pkg::ST_IDLE;
         end
      endcase

      // a fresh write restarts the recompute from the top
      if (cfg_hit) begin
         state_in = brp_pkg::ST_MUL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff           <= 1'b0;
         tx_speed_ff      <= brp_pkg::SPEED_RESET;
         rx_speed_ff      <= brp_pkg::SPEED_RESET;
         next_recv_ff     <= '0;
         next_send_ff     <= '0;
         recv_interval_ff <= brp_pkg::PRESET_INTERVAL;
         send_interval_ff <= brp_pkg::PRESET_INTERVAL;
         rsp_valid_ff     <= 1'b0;
         state_ff         <= brp_pkg::ST_IDLE;
         cnt_ff           <= '0;
      end else begin
         src_ff           <= src_in;
         tx_speed_ff      <= tx_speed_in;
         rx_speed_ff      <= rx_speed_in;
         next_recv_ff     <= next_recv_in;
         next_send_ff     <= next_send_in;
         recv_interval_ff <= recv_interval_in;
         send_interval_ff <= send_interval_in;
         rsp_valid_ff     <= rsp_valid_in;
         state_ff         <= state_in;
         cnt_ff           <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rx_prod_ff  <= rx_prod_in;
      tx_prod_ff  <= tx_prod_in;
      rx_eff_ff   <= rx_eff_in;
      tx_eff_ff   <= tx_eff_in;
      rx_rem_ff   <= rx_rem_in;
      tx_rem_ff   <= tx_rem_in;
      rx_quot_ff  <= rx_quot_in;
      tx_quot_ff  <= tx_quot_in;
      dvd_ff      <= dvd_in;
   end

   // a zero wait and the ready flag always agree
   a_read_ready_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[2*WAIT_W] == (rsp_data_ff[WAIT_W-1:0] == '0)))
      else $error("read_ready disagrees with read wait");

   a_write_ready_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[2*WAIT_W+1] == (rsp_data_ff[2*WAIT_W-1:WAIT_W] == '0)))
      else $error("write_ready disagrees with write wait");

   // no transaction may use intervals while they are being recomputed
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != brp_pkg::ST_IDLE) |-> !req_fire)
      else $error("transaction accepted during interval recompute");

   // a finished recompute never leaves a zero interval
   a_interval_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == brp_pkg::ST_DONE && !cfg_hit) |=>
         (recv_interval_ff != '0 && send_interval_ff != '0))
      else $error("zero interval after recompute");

endmodule
